// File: sv/cpht_pkg.sv
// package: commands, status codes and the key hash for the chained hash table
`default_nettype none
package cpht_pkg;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_NOT_FOUND = 3'd0,
        ST_FOUND     = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_REPLACED  = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    localparam int KEY_W = 64;
    localparam int VAL_W = 64;
    localparam int COUNT_W = 11;

    // first half of the mix, up to the multiply by nine
    function automatic logic [63:0] hash_front(input logic [63:0] k);
        logic [63:0] h;
        h = ~(k << 32) + k;
        h = h ^ 64'($signed(h) >>> 22);
        h = h + ~(h << 13);
        h = h ^ 64'($signed(h) >>> 8);
        return h;
    endfunction

    // second half, after the multiply by nine
    function automatic logic [63:0] hash_back(input logic [63:0] g);
        logic [63:0] h;
        h = g ^ 64'($signed(g) >>> 15);
        h = h + ~(h << 27);
        h = h ^ 64'($signed(h) >>> 31);
        return h;
    endfunction

endpackage
`default_nettype wire

// File: sv/cpht_if.sv
// interface: valid/ready channel carrying a request or a result payload
`default_nettype none
interface cpht_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/cpht_ctrl.sv
// controller: sequences hash, chain walk, update and result handoff
`default_nettype none
module cpht_ctrl (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output logic      start,
    output logic      hash_step,
    output logic      walk_read,
    output logic      node_read,
    output logic      walk_check,
    output logic      finish,
    input  wire logic walk_done
);
    typedef enum logic [2:0] {S_IDLE, S_HASH1, S_HASH2, S_HEAD, S_WAIT, S_CHECK, S_DONE, S_OUT}
        state_t;
    state_t state_reg, state_next;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign start      = in_valid && in_ready;
    assign hash_step  = (state_reg == S_HASH1) || (state_reg == S_HASH2);
    assign walk_read  = (state_reg == S_HEAD);
    assign node_read  = (state_reg == S_WAIT);
    assign walk_check = (state_reg == S_CHECK);
    assign finish     = (state_reg == S_DONE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_HASH1;
            S_HASH1: state_next = S_HASH2;
            S_HASH2: state_next = S_HEAD;
            S_HEAD:  state_next = S_WAIT;
            S_WAIT:  state_next = S_CHECK;
            S_CHECK: state_next = walk_done ? S_DONE : S_WAIT;
            S_DONE:  state_next = S_OUT;
            S_OUT:   if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

// File: sv/cpht_datapath.sv
// datapath: hash, bucket heads, node memories, spare list and counters
`default_nettype none
module cpht_datapath #(
    parameter int BUCKET_BITS = 8,
    parameter int NODES = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic                     hash_step,
    input  wire logic                     walk_read,
    input  wire logic                     node_read,
    input  wire logic                     walk_check,
    input  wire logic                     finish,
    output logic                          walk_done,
    input  wire cpht_pkg::cmd_t           cmd,
    input  wire logic [63:0]              key,
    input  wire logic [63:0]              value,
    output cpht_pkg::status_t             status,
    output logic [63:0]                   value_out,
    output logic [cpht_pkg::COUNT_W-1:0]  entry_count
);
    import cpht_pkg::*;

    localparam int NB = 1 << BUCKET_BITS;
    localparam int LW = $clog2(NODES + 1);
    localparam int IW = $clog2(NODES);
    localparam logic [LW-1:0] NIL = LW'(NODES);

    logic [LW-1:0] head_mem [NB];
    logic [NB-1:0] head_vld_reg;
    logic [63:0]   key_mem [NODES];
    logic [63:0]   val_mem [NODES];
    logic [LW-1:0] next_mem [NODES];

    cmd_t          cmd_reg;
    logic [63:0]   key_reg, val_reg, h_reg;
    logic          hphase_reg;
    logic [BUCKET_BITS-1:0] bkt_reg;
    logic [LW-1:0] prev_reg, cur_reg, head_rd_reg;
    logic          head_rd_vld_reg;
    logic          found_reg, head_phase_reg;
    logic [63:0]   rk_reg, rv_reg;
    logic [LW-1:0] rn_reg, spare_nx_reg;
    logic [LW-1:0] spare_reg, fresh_reg;
    logic [COUNT_W-1:0] held_reg;
    status_t       status_reg;
    logic [63:0]   vout_reg;
    logic          fix_reg;
    logic [LW-1:0] fix_addr_reg, fix_data_reg;

    logic [LW-1:0] head_val;
    logic [LW-1:0] cur_eff;
    logic          is_nil;
    logic [63:0]   h_mul;

    assign h_mul    = (h_reg << 3) + h_reg;
    assign head_val = head_rd_vld_reg ? head_rd_reg : NIL;
    assign cur_eff  = head_phase_reg ? head_val : cur_reg;
    assign is_nil   = (cur_eff == NIL);
    assign walk_done = walk_check && (is_nil || rk_reg == key_reg || cmd_reg == CMD_NONE);

    assign status      = status_reg;
    assign value_out   = vout_reg;
    assign entry_count = held_reg;

    // node reads: one address per cycle, registered
    always_ff @(posedge clk)
    begin
        if (node_read)
        begin
            rk_reg <= key_mem[IW'(cur_eff)];
            rv_reg <= val_mem[IW'(cur_eff)];
            rn_reg <= next_mem[IW'(cur_eff)];
        end
        else if (walk_done)
        begin
            spare_nx_reg <= next_mem[IW'(spare_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cmd_reg <= cmd_t'(cmd);
            key_reg <= key;
            val_reg <= value;
            h_reg   <= hash_front(key);
            hphase_reg <= 1'b0;
        end
        else if (hash_step)
        begin
            if (!hphase_reg)
                h_reg <= h_mul;
            else
                bkt_reg <= BUCKET_BITS'(hash_back(h_reg));
            hphase_reg <= 1'b1;
        end
        if (walk_read)
        begin
            head_rd_reg     <= head_mem[bkt_reg];
            head_rd_vld_reg <= head_vld_reg[bkt_reg];
            head_phase_reg  <= 1'b1;
            prev_reg        <= NIL;
        end
        else if (walk_check && !walk_done)
        begin
            prev_reg       <= cur_eff;
            cur_reg        <= rn_reg;
            head_phase_reg <= 1'b0;
        end
        else if (walk_check)
        begin
            cur_reg        <= cur_eff;
            found_reg      <= !is_nil;
            head_phase_reg <= 1'b0;
        end
    end

    // memory writes in the finish cycle, predecessor link on the cycle after
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            if (cmd_reg == CMD_INSERT && found_reg)
                val_mem[IW'(cur_reg)] <= val_reg;
            else if (cmd_reg == CMD_INSERT && (spare_reg != NIL || fresh_reg != NIL))
            begin
                key_mem[IW'(spare_reg != NIL ? spare_reg : fresh_reg)]  <= key_reg;
                val_mem[IW'(spare_reg != NIL ? spare_reg : fresh_reg)]  <= val_reg;
                next_mem[IW'(spare_reg != NIL ? spare_reg : fresh_reg)] <= head_val;
                head_mem[bkt_reg] <= spare_reg != NIL ? spare_reg : fresh_reg;
            end
            else if (cmd_reg == CMD_REMOVE && found_reg)
            begin
                next_mem[IW'(cur_reg)] <= spare_reg;
                if (prev_reg == NIL)
                    head_mem[bkt_reg] <= rn_reg;
            end
        end
        else if (fix_reg)
            next_mem[IW'(fix_addr_reg)] <= fix_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fix_reg <= 1'b0;
        else
            fix_reg <= finish && cmd_reg == CMD_REMOVE && found_reg && prev_reg != NIL;
    end
    always_ff @(posedge clk)
    begin
        fix_addr_reg <= prev_reg;
        fix_data_reg <= rn_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg <= '0;
            spare_reg    <= NIL;
            fresh_reg    <= '0;
            held_reg     <= '0;
            status_reg   <= ST_NOT_FOUND;
            vout_reg     <= '0;
        end
        else if (finish)
        begin
            status_reg <= ST_NOT_FOUND;
            vout_reg   <= '0;
            unique case (cmd_reg)
                CMD_LOOKUP:
                    if (found_reg)
                    begin
                        status_reg <= ST_FOUND;
                        vout_reg   <= rv_reg;
                    end
                CMD_INSERT:
                    if (found_reg)
                    begin
                        status_reg <= ST_REPLACED;
                        vout_reg   <= rv_reg;
                    end
                    else if (spare_reg != NIL || fresh_reg != NIL)
                    begin
                        status_reg <= ST_INSERTED;
                        head_vld_reg[bkt_reg] <= 1'b1;
                        held_reg <= held_reg + 1'b1;
                        if (spare_reg != NIL)
                            spare_reg <= spare_nx_reg;
                        else
                            fresh_reg <= fresh_reg + 1'b1;
                    end
                    else
                        status_reg <= ST_FULL;
                CMD_REMOVE:
                    if (found_reg)
                    begin
                        status_reg <= ST_FOUND;
                        vout_reg   <= rv_reg;
                        spare_reg  <= cur_reg;
                        head_vld_reg[bkt_reg] <= 1'b1;
                        if (held_reg != '0)
                            held_reg <= held_reg - 1'b1;
                    end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: sv/chained_pointer_hash_table_core.sv
// top level: chained hash table, controller plus datapath
//
// requests arrive on req (cmd, key, value); one result per request leaves on rsp
// (status, value_out, entry_count). cmd 0 lookup, 1 insert or replace, 2 remove;
// code 3 is answered as not found and changes nothing.
// one request at a time: the accept, the hash multiply and back half, a
// registered bucket head read, then per chain step a node memory read and a
// key compare, then the update and the result. a walk takes one step
// per node compared, plus one when it runs off the chain end, so an empty
// bucket still costs one step. the single node memory read port and the
// chain walk set the request time.
// the result holds on rsp until taken; no new request is accepted meanwhile,
// so a stall adds its length to the request time.
// reset empties all buckets, the spare list and the entry count at once via
// per-bucket valid bits; node memories need no clearing.
// an insert with no spare and no unused node returns status 4.
`default_nettype none
module chained_pointer_hash_table_core #(
    parameter int BUCKET_BITS = 8,
    parameter int NODES = 1024
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cpht_if.sink      req,
    cpht_if.source    rsp
);
    import cpht_pkg::*;

    logic start, hash_step, walk_read, node_read, walk_check, finish, walk_done;
    status_t status;
    logic [63:0] value_out;
    logic [COUNT_W-1:0] entry_count;

    cpht_ctrl u_ctrl (
        .clk, .rst_n,
        .in_valid(req.valid), .in_ready(req.ready),
        .out_valid(rsp.valid), .out_ready(rsp.ready),
        .start, .hash_step, .walk_read, .node_read, .walk_check, .finish, .walk_done
    );

    cpht_datapath #(.BUCKET_BITS(BUCKET_BITS), .NODES(NODES)) u_dp (
        .clk, .rst_n, .start, .hash_step, .walk_read, .node_read, .walk_check, .finish,
        .walk_done,
        .cmd(cmd_t'(req.data.cmd)), .key(req.data.key), .value(req.data.value),
        .status, .value_out, .entry_count
    );

    assign rsp.data.status      = status;
    assign rsp.data.value_out   = value_out;
    assign rsp.data.entry_count = entry_count;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && rsp.valid)) else $error("request taken while result pending");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count <= COUNT_W'(NODES)) else $error("entry count beyond pool");
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (status == ST_FULL || status == ST_INSERTED || status == ST_NOT_FOUND)
        |-> value_out == '0) else $error("nonzero value with empty status");
endmodule
`default_nettype wire
